### design/rau_pkg.sv
package rau_pkg;

   localparam int OperandBits = 32;
   localparam int NormBits = OperandBits + 1;
   localparam int ProdBits = 2 * OperandBits;
   localparam int MagBits = 64;
   localparam int ShiftBits = 7;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   typedef struct packed {
      logic [1:0] opcode;
      logic signed [31:0] a_num;
      logic signed [31:0] a_den;
      logic signed [31:0] b_num;
      logic signed [31:0] b_den;
   } req_type;

   typedef struct packed {
      logic signed [63:0] res_num;
      logic [62:0] res_den;
      logic div_zero;
      logic a_less;
      logic a_equal;
   } rsp_type;

   // unreduced job handed from front to back
   typedef struct packed {
      logic neg;
      logic [MagBits-1:0] mag;
      logic [MagBits-1:0] den;
      logic div_zero;
      logic a_less;
      logic a_equal;
   } job_type;

   typedef enum logic [2:0] {
      FE_IDLE, FE_MUL1, FE_MUL2, FE_FORM
   } fe_state_type;

   typedef enum logic [2:0] {
      BE_IDLE, BE_GCD, BE_DIV_NUM, BE_DIV_DEN, BE_DONE
   } be_state_type;

endpackage

### design/rau_front.sv
module rau_front import rau_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  req_type req_item,
   output logic busy,
   output logic job_valid,
   output job_type job,
   input  logic job_ready
);

   fe_state_type state_ff, state_in;
   logic [1:0] op_ff;
   logic signed [NormBits-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic signed [ProdBits-1:0] p_ff, q_ff, nab_ff;
   logic [MagBits-1:0] dd_ff;
   logic signed [NormBits-1:0] an_c, ad_c, bn_c, bd_c;

   function automatic logic signed [NormBits-1:0] sx(input logic [31:0] v);
      sx = NormBits'(signed'(v[OperandBits-1:0]));
   endfunction

   function automatic logic [MagBits-1:0] mag(input logic signed [ProdBits-1:0] x);
      mag = x[ProdBits-1] ? MagBits'(-x) : MagBits'(x);
   endfunction

   function automatic logic [OperandBits-1:0] mag_n(input logic signed [NormBits-1:0] x);
      mag_n = x[NormBits-1] ? OperandBits'(-x) : OperandBits'(x);
   endfunction

   always_comb begin
      logic signed [NormBits-1:0] n, d;
      n = sx(req_item.a_num);
      d = sx(req_item.a_den);
      if (d == '0) begin
         n = NormBits'(1);
         d = NormBits'(1);
      end
      if (d[NormBits-1]) begin
         n = -n;
         d = -d;
      end
      an_c = n;
      ad_c = d;
      n = sx(req_item.b_num);
      d = sx(req_item.b_den);
      if (d == '0) begin
         n = NormBits'(1);
         d = NormBits'(1);
      end
      if (d[NormBits-1]) begin
         n = -n;
         d = -d;
      end
      bn_c = n;
      bd_c = d;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= FE_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         FE_IDLE: if (start) begin
            op_ff <= req_item.opcode;
            an_ff <= an_c;
            ad_ff <= ad_c;
            bn_ff <= bn_c;
            bd_ff <= bd_c;
         end
         FE_MUL1: begin
            p_ff <= ProdBits'(an_ff * bd_ff);
            q_ff <= ProdBits'(bn_ff * ad_ff);
         end
         FE_MUL2: begin
            nab_ff <= ProdBits'(an_ff * bn_ff);
            dd_ff <= (op_ff == OP_DIV) ? MagBits'(mag_n(ad_ff) * mag_n(bn_ff))
                                       : MagBits'(mag_n(ad_ff) * mag_n(bd_ff));
         end
         default: ;
      endcase
   end

   always_comb begin
      logic signed [ProdBits:0] s;
      state_in = state_ff;
      busy = (state_ff != FE_IDLE);
      job_valid = 1'b0;
      job = '0;
      s = '0;
      unique case (state_ff)
         FE_IDLE: if (start) state_in = FE_MUL1;
         FE_MUL1: state_in = FE_MUL2;
         FE_MUL2: state_in = FE_FORM;
         FE_FORM: begin
            job_valid = 1'b1;
            job.a_less = (p_ff < q_ff);
            job.a_equal = (p_ff == q_ff);
            job.den = dd_ff;
            unique case (op_ff) inside
               OP_ADD, OP_SUB: begin
                  s = (op_ff == OP_ADD) ? {p_ff[ProdBits-1], p_ff} + {q_ff[ProdBits-1], q_ff}
                                        : {p_ff[ProdBits-1], p_ff} - {q_ff[ProdBits-1], q_ff};
                  job.neg = s[ProdBits];
                  job.mag = s[ProdBits] ? MagBits'(-s) : MagBits'(s);
               end
               OP_MUL: begin
                  job.neg = nab_ff[ProdBits-1];
                  job.mag = mag(nab_ff);
               end
               default: begin
                  if (bn_ff == '0) begin
                     job.div_zero = 1'b1;
                     job.mag = MagBits'(1);
                     job.den = MagBits'(1);
                  end else begin
                     job.neg = p_ff[ProdBits-1] ^ bn_ff[NormBits-1];
                     job.mag = mag(p_ff);
                  end
               end
            endcase
            if (job_ready) state_in = FE_IDLE;
         end
         default: state_in = FE_IDLE;
      endcase
   end

endmodule

### design/rau_queue.sv
module rau_queue import rau_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  job_type in_job,
   output logic in_ready,
   output logic out_valid,
   output job_type out_job,
   input  logic out_take
);

   job_type mem_ff [2];
   logic wr_ff, rd_ff;
   logic [1:0] cnt_ff;

   assign in_ready = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_job = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) mem_ff[wr_ff] <= in_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (in_valid && in_ready) wr_ff <= ~wr_ff;
         if (out_take && out_valid) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + 2'(in_valid && in_ready) - 2'(out_take && out_valid);
      end
   end

endmodule

### design/rau_back.sv
module rau_back import rau_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic job_valid,
   input  job_type job,
   output logic job_take,
   output logic rsp_valid,
   output rsp_type rsp_item
);

   be_state_type state_ff, state_in;
   job_type job_ff;
   logic [MagBits-1:0] ga_ff, gb_ff, g_ff;
   logic [MagBits-1:0] rem_ff, quo_ff, qn_ff;
   logic [ShiftBits-1:0] bit_ff, sh_ff;

   logic [MagBits-1:0] dvd;
   logic [MagBits:0] rem_sh;
   logic fits;
   always_comb begin
      dvd = (state_ff == BE_DIV_NUM) ? job_ff.mag : job_ff.den;
      rem_sh = {rem_ff, dvd[bit_ff[5:0]]};
      fits = (rem_sh >= {1'b0, g_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= BE_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         BE_IDLE: if (job_valid) begin
            job_ff <= job;
            ga_ff <= job.mag;
            gb_ff <= job.den;
            sh_ff <= '0;
         end
         BE_GCD: begin
            // Binary gcd: strip common twos, halve an even value, else subtract
            // the smaller odd value from the larger. The denominator is never
            // zero, so the loop ends when the first value reaches zero.
            if (ga_ff == '0) begin
               g_ff <= gb_ff << sh_ff;
               rem_ff <= '0;
               quo_ff <= '0;
               bit_ff <= ShiftBits'(MagBits - 1);
            end else if (!ga_ff[0] && !gb_ff[0]) begin
               ga_ff <= ga_ff >> 1;
               gb_ff <= gb_ff >> 1;
               sh_ff <= sh_ff + ShiftBits'(1);
            end else if (!ga_ff[0]) begin
               ga_ff <= ga_ff >> 1;
            end else if (!gb_ff[0]) begin
               gb_ff <= gb_ff >> 1;
            end else if (ga_ff >= gb_ff) begin
               ga_ff <= ga_ff - gb_ff;
            end else begin
               gb_ff <= gb_ff - ga_ff;
            end
         end
         BE_DIV_NUM, BE_DIV_DEN: begin
            quo_ff <= {quo_ff[MagBits-2:0], fits};
            if (bit_ff == '0) begin
               bit_ff <= ShiftBits'(MagBits - 1);
               rem_ff <= '0;
               if (state_ff == BE_DIV_NUM)
                  qn_ff <= {quo_ff[MagBits-2:0], fits};
            end else begin
               bit_ff <= bit_ff - ShiftBits'(1);
               rem_ff <= fits ? MagBits'(rem_sh - {1'b0, g_ff}) : rem_sh[MagBits-1:0];
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      job_take = 1'b0;
      rsp_valid = 1'b0;
      rsp_item = '0;
      unique case (state_ff)
         BE_IDLE: if (job_valid) begin
            job_take = 1'b1;
            state_in = BE_GCD;
         end
         BE_GCD: if (ga_ff == '0) state_in = (job_ff.mag == '0) ? BE_DONE : BE_DIV_NUM;
         BE_DIV_NUM: if (bit_ff == '0) state_in = BE_DIV_DEN;
         BE_DIV_DEN: if (bit_ff == '0) state_in = BE_DONE;
         BE_DONE: begin
            rsp_valid = 1'b1;
            rsp_item.div_zero = job_ff.div_zero;
            rsp_item.a_less = job_ff.a_less;
            rsp_item.a_equal = job_ff.a_equal;
            if (job_ff.mag == '0) begin
               rsp_item.res_num = '0;
               rsp_item.res_den = 63'd1;
            end else begin
               rsp_item.res_num = job_ff.neg ? -qn_ff : qn_ff;
               rsp_item.res_den = quo_ff[62:0];
            end
            state_in = BE_IDLE;
         end
         default: state_in = BE_IDLE;
      endcase
   end

endmodule

### design/rational_arith_unit.sv
// Rational arithmetic unit: add, subtract, multiply or divide two fractions,
// result reduced by the gcd with a positive denominator, plus value compare
// flags. Results appear for one cycle on rsp_valid and cannot be stalled.
// The front takes a new item only after it has handed the last job to the
// queue; the back runs a binary gcd (one shift or subtract per cycle, data
// dependent) and two restoring divisions by the gcd, one for the numerator
// and one for the denominator; a zero result skips the divisions. A two-entry
// queue parts front and back; busy drops when the front is free, so once the
// queue is full the input waits on the back.
module rational_arith_unit import rau_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  req_type req_item,
   output logic rsp_valid,
   output rsp_type rsp_item
);

   logic fe_valid, q_ready, q_valid, q_take;
   job_type fe_job, q_job;

   rau_front u_front (
      .clock, .reset, .start, .req_item, .busy,
      .job_valid(fe_valid), .job(fe_job), .job_ready(q_ready)
   );

   rau_queue u_queue (
      .clock, .reset,
      .in_valid(fe_valid), .in_job(fe_job), .in_ready(q_ready),
      .out_valid(q_valid), .out_job(q_job), .out_take(q_take)
   );

   rau_back u_back (
      .clock, .reset,
      .job_valid(q_valid), .job(q_job), .job_take(q_take),
      .rsp_valid, .rsp_item
   );

`ifndef ASSERT_OFF
   a_den_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.res_den != '0) else $error("zero denominator");
   a_dz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.div_zero |-> rsp_item.res_num == 64'sd1)
      else $error("div zero result");
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_item.a_less && rsp_item.a_equal)) else $error("flags");
`endif

endmodule

### bench/rational_arith_unit_test.sv
`timescale 1ns / 1ps

module rational_arith_unit_test;
   import rau_pkg::*;

   localparam int LimitCycles = 3000000;
   localparam int RandomItems = 400;
   localparam int DrainCycles = 1000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_item = '0;
   logic rsp_valid;
   rsp_type rsp_item;

   rsp_type fraction_q[$];
   int mismatches = 0;
   int cycles = 0;

   rational_arith_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LimitCycles) begin
         $display("FAIL rational_arith_unit");
         $finish;
      end
   end

   function automatic longint unsigned magnitude(longint x);
      return x < 0 ? 64'd0 - 64'(x) : 64'(x);
   endfunction

   function automatic longint unsigned euclid(longint unsigned a, longint unsigned b);
      longint unsigned t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   // sum of two cross products as sign and 64-bit magnitude
   function automatic void signed_sum(longint p, longint q, output bit neg,
                                      output longint unsigned mag);
      longint s;
      if (p >= 0 && q >= 0) begin
         neg = 1'b0;
         mag = 64'(p) + 64'(q);
      end else if (p < 0 && q < 0) begin
         neg = 1'b1;
         mag = magnitude(p) + magnitude(q);
      end else begin
         s = p + q;
         neg = s < 0;
         mag = magnitude(s);
      end
   endfunction

   function automatic rsp_type reduce_fraction(req_type r);
      longint an, ad, bn, bd, p, q, n;
      longint unsigned mag, den, g;
      bit neg, dz;
      rsp_type o;
      an = longint'(r.a_num);
      ad = longint'(r.a_den);
      bn = longint'(r.b_num);
      bd = longint'(r.b_den);
      neg = 1'b0;
      dz = 1'b0;
      mag = 1;
      den = 1;
      // zero denominator makes the operand 1/1
      if (ad == 0) begin
         an = 1;
         ad = 1;
      end
      if (ad < 0) begin
         ad = -ad;
         an = -an;
      end
      if (bd == 0) begin
         bn = 1;
         bd = 1;
      end
      if (bd < 0) begin
         bd = -bd;
         bn = -bn;
      end
      p = an * bd;
      q = bn * ad;
      case (r.opcode)
         OP_ADD: begin
            signed_sum(p, q, neg, mag);
            den = 64'(ad) * 64'(bd);
         end
         OP_SUB: begin
            signed_sum(p, -q, neg, mag);
            den = 64'(ad) * 64'(bd);
         end
         OP_MUL: begin
            n = an * bn;
            neg = n < 0;
            mag = magnitude(n);
            den = 64'(ad) * 64'(bd);
         end
         default: begin
            if (bn == 0) begin
               dz = 1'b1;
            end else begin
               n = an * bd;
               neg = (n < 0) != (bn < 0);
               mag = magnitude(n);
               den = 64'(ad) * magnitude(bn);
            end
         end
      endcase
      if (mag == 0) begin
         neg = 1'b0;
         den = 1;
      end else begin
         g = euclid(mag, den);
         mag = mag / g;
         den = den / g;
      end
      o.res_num = neg ? 64'd0 - mag : mag;
      o.res_den = den[62:0];
      o.div_zero = dz;
      o.a_less = p < q;
      o.a_equal = p == q;
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (fraction_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result %p", rsp_item);
         end else begin
            want = fraction_q.pop_front();
            if (rsp_item.res_num !== want.res_num || rsp_item.res_den !== want.res_den ||
                rsp_item.div_zero !== want.div_zero || rsp_item.a_less !== want.a_less ||
                rsp_item.a_equal !== want.a_equal) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", want, rsp_item);
            end
         end
      end
   end

   // hold start and the item until an edge with busy low takes it
   task automatic send_item(logic [1:0] op, int an, int ad, int bn, int bd);
      req_type r;
      r.opcode = op;
      r.a_num = an;
      r.a_den = ad;
      r.b_num = bn;
      r.b_den = bd;
      @(negedge clock);
      start = 1'b1;
      req_item = r;
      do @(posedge clock); while (busy);
      fraction_q.push_back(reduce_fraction(r));
   endtask

   task automatic idle_gap(bit allow);
      int n, k;
      k = $urandom_range(0, 99);
      if (!allow || k < 55) return;
      n = k < 90 ? $urandom_range(1, 6) : $urandom_range(20, 400);
      @(negedge clock);
      start = 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic drain_results();
      @(negedge clock);
      start = 1'b0;
      while (fraction_q.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      logic [1:0] op;
      for (int i = 0; i < 4; i++) begin
         op = i[1:0];
         send_item(op, 1, 2, 1, 3);
         idle_gap(1'b1);
      end
      send_item(OP_ADD, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      send_item(OP_SUB, 32'h7fff_ffff, 32'h8000_0001, 32'h8000_0000, 1);
      send_item(OP_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
      send_item(OP_MUL, 32'h7fff_ffff, 32'h8000_0001, 32'h7fff_ffff, 32'h7fff_ffff);
      send_item(OP_DIV, 32'h8000_0000, 1, 1, 32'h7fff_ffff);
      send_item(OP_DIV, 32'h7fff_ffff, 32'h8000_0001, 32'h8000_0000, 32'h7fff_ffff);
      // zero denominators and division by a zero numerator
      send_item(OP_ADD, 5, 0, 3, 4);
      send_item(OP_MUL, 7, 3, -9, 0);
      send_item(OP_DIV, 3, 4, 0, 5);
      send_item(OP_DIV, -3, 4, 0, 0);
      send_item(OP_DIV, 6, -4, 0, -7);
      // zero results and equal values in different forms
      send_item(OP_SUB, 2, 4, -3, -6);
      send_item(OP_MUL, 0, 9, 5, 7);
      send_item(OP_ADD, 1, 3, -1, 3);
      send_item(OP_SUB, -5, 10, 5, 10);
      send_item(OP_DIV, 0, -3, 4, 0);
      send_item(OP_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
      send_item(OP_SUB, 32'h8000_0000, 1, 32'h7fff_ffff, 1);
      send_item(OP_ADD, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_fffe);
      drain_results();
   endtask

   function automatic int pick_value(bit den_field);
      int k;
      int v;
      k = $urandom_range(0, 99);
      if (k < 40) v = $urandom_range(0, 40) - 20;
      else if (k < 55) v = $urandom_range(0, 2000) - 1000;
      else if (k < 65) v = $urandom_range(0, 7) - 4 + (k[0] ? 32'h7fff_fffc : 32'h8000_0004);
      else v = $urandom;
      if (den_field && v == 32'h8000_0000) v = 32'h8000_0001;
      if (den_field && k < 5) v = 0;
      return v;
   endfunction

   task automatic test_random();
      logic [1:0] op;
      for (int i = 0; i < RandomItems; i++) begin
         op = 2'($urandom_range(0, 3));
         if ($urandom_range(0, 9) == 0)
            send_item(OP_DIV, pick_value(1'b0), pick_value(1'b1), 0, pick_value(1'b1));
         else
            send_item(op, pick_value(1'b0), pick_value(1'b1), pick_value(1'b0),
                      pick_value(1'b1));
         // back-to-back for the first stretch, gaps afterwards
         idle_gap(i >= 60);
         if (i == RandomItems / 2) drain_results();
      end
      drain_results();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random();
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0 && fraction_q.size() == 0) begin
         $display("PASS rational_arith_unit");
      end else begin
         $display("FAIL rational_arith_unit");
      end
      $finish;
   end

endmodule
